// ===== hw/rtl/salc_pkg.sv =====
// salc_pkg: shared constants, codes and types of the set-associative lru cache model
// no dependencies; used by salc_if.sv, salc_access.sv and set_assoc_lru_cache_sim.sv
package salc_pkg;

  localparam int MAX_SETS_DEF = 64;
  localparam int MAX_WAYS_DEF = 8;

  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int CNT_W        = 32;
  localparam int CMD_W        = 2;
  localparam int OUTCOME_W    = 2;

  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 2;

  // widest raw set index that set_bits can select, and the table depth for it
  localparam int SET_RAW_W    = (1 << SET_BITS_W) - 1;
  localparam int SET_RAW_N    = 1 << SET_RAW_W;

  // tag shift is set_bits + block_bits, up to 38
  localparam int SHIFT_W      = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD,
    CMD_STORE,
    CMD_MODIFY,
    CMD_INSTR
  } cmd_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT,
    OUT_MISS,
    OUT_EVICT,
    OUT_IGNORED
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS,
    REG_BLOCK_BITS,
    REG_WAYS_IN_USE
  } reg_idx_t;

  typedef struct packed {
    outcome_t outcome;
    logic     hit;
    logic     evict;
  } acc_res_t;

endpackage

// ===== hw/rtl/salc_if.sv =====
// salc_if: valid/ready channels for access words and result words
// depends on salc_pkg for field widths
interface salc_in_if;
  logic                         valid;
  logic                         ready;
  logic [salc_pkg::CMD_W-1:0]   command;
  logic [salc_pkg::ADDR_W-1:0]  address;

  modport source (output valid, command, address, input ready);
  modport sink   (input valid, command, address, output ready);
endinterface

interface salc_out_if;
  logic                            valid;
  logic                            ready;
  logic [salc_pkg::OUTCOME_W-1:0]  outcome;
  logic                            second_hit;
  logic [salc_pkg::CNT_W-1:0]      hit_total;
  logic [salc_pkg::CNT_W-1:0]      miss_total;
  logic [salc_pkg::CNT_W-1:0]      eviction_total;

  modport source (output valid, outcome, second_hit, hit_total, miss_total, eviction_total,
                  input ready);
  modport sink   (input valid, outcome, second_hit, hit_total, miss_total, eviction_total,
                  output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_sim.sv =====
// set_assoc_lru_cache_sim: tag-only set-associative cache with true lru replacement
// depends on salc_pkg, salc_if (salc_in_if, salc_out_if) and salc_access
//
// usage:
//   access channel: one word per access, command and byte address. result channel:
//   exactly one word per access, with the outcome of the first access, the hit flag
//   of a modify's second access and the running hit, miss and eviction counts.
//   cfg_we / cfg_index / cfg_data write set_bits, block_bits and ways_in_use; write
//   only while no access is in flight.
// access flow:
//   each set is one row of a synchronous memory. an accepted word reads its row at the
//   accept edge; in ST_ACC1 the row is updated and written back (not for an instruction
//   word) and the result register loads (not for a modify, whose second access works
//   on the held row in ST_ACC2 and loads it). a new word is accepted only in ST_IDLE,
//   once the previous word is through.
// reset:
//   rst clears the counters, the result valid flag and the state and resets the
//   configuration, then a clear pass writes every set row to zero, with access.ready low.
// stalls:
//   the result register holds while result.ready is low; the next word is still
//   accepted and waits with its update until the register frees up.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  salc_in_if.sink                              access,
  salc_out_if.source                           result,
  input  logic                                 cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RAW_W = salc_pkg::SET_RAW_W;
  localparam int RAW_N = salc_pkg::SET_RAW_N;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  typedef struct packed {
    logic [MAX_WAYS-1:0]                       valid;
    logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]            age;
  } row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC1,
    ST_ACC2
  } state_t;

  // configuration
  logic [salc_pkg::SET_BITS_W-1:0]   set_bits;
  logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits;
  logic [salc_pkg::WAYS_W-1:0]       ways_in_use;
  logic [MAX_WAYS-1:0]               way_en;

  // address split
  logic [salc_pkg::ADDR_W-1:0] addr_shifted;
  logic [RAW_W-1:0]            set_mask;
  logic [RAW_W-1:0]            raw_set;
  logic [SET_W-1:0]            set_wrap [RAW_N];
  logic [SET_W-1:0]            set_idx;
  logic [salc_pkg::SHIFT_W-1:0] tag_shift;
  logic [salc_pkg::TAG_W-1:0]  tag_val;

  // set memory
  row_t              mem [MAX_SETS];
  row_t              rd_row;
  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  row_t              mem_wdata;

  // control and held access
  state_t                      state;
  logic [SET_W-1:0]            clr_idx;
  salc_pkg::cmd_t              cmd_r;
  logic [SET_W-1:0]            set_r;
  logic [salc_pkg::TAG_W-1:0]  tag_r;
  row_t                        row_hold;
  salc_pkg::outcome_t          first_outcome;
  logic                        acc_fire;
  logic                        is_modify;
  logic                        is_ignored;
  logic                        out_free;
  logic                        step;
  logic                        out_load;
  logic                        count_en;

  // access unit
  row_t                row_cur;
  row_t                row_new;
  salc_pkg::acc_res_t  acc_res;

  // counters and result register
  logic [salc_pkg::CNT_W-1:0]     hits_seen;
  logic [salc_pkg::CNT_W-1:0]     misses_seen;
  logic [salc_pkg::CNT_W-1:0]     evictions_seen;
  logic [salc_pkg::CNT_W-1:0]     hits_seen_next;
  logic [salc_pkg::CNT_W-1:0]     misses_seen_next;
  logic [salc_pkg::CNT_W-1:0]     evictions_seen_next;
  logic                           res_valid;
  logic [salc_pkg::OUTCOME_W-1:0] res_outcome;
  logic                           res_second_hit;
  logic [salc_pkg::CNT_W-1:0]     res_hit_total;
  logic [salc_pkg::CNT_W-1:0]     res_miss_total;
  logic [salc_pkg::CNT_W-1:0]     res_eviction_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= salc_pkg::WAYS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        salc_pkg::REG_SET_BITS:    set_bits    <= cfg_data[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::REG_BLOCK_BITS:  block_bits  <= cfg_data[salc_pkg::BLOCK_BITS_W-1:0];
        salc_pkg::REG_WAYS_IN_USE: ways_in_use <= cfg_data[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero ways act as one, anything above MAX_WAYS as MAX_WAYS
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_en[i] = (i == 0) || (int'(ways_in_use) > i);
    end
  end

  for (genvar g = 0; g < RAW_N; g++) begin : g_set_wrap
    assign set_wrap[g] = SET_W'(g % MAX_SETS);
  end

  assign addr_shifted = access.address >> block_bits;
  assign set_mask     = ~({RAW_W{1'b1}} << set_bits);
  assign raw_set      = addr_shifted[RAW_W-1:0] & set_mask;
  assign set_idx      = set_wrap[raw_set];
  assign tag_shift    = salc_pkg::SHIFT_W'(set_bits) + salc_pkg::SHIFT_W'(block_bits);
  assign tag_val      = tag_shift[salc_pkg::SHIFT_W-1] ? '0 :
                        (access.address >> tag_shift[salc_pkg::SHIFT_W-2:0]);

  assign access.ready = (state == ST_IDLE);
  assign acc_fire     = access.valid && access.ready;

  assign is_modify  = (cmd_r == salc_pkg::CMD_MODIFY);
  assign is_ignored = (cmd_r == salc_pkg::CMD_INSTR);
  assign out_free   = !res_valid || result.ready;
  // the first access of a modify does not need the result register
  assign step       = ((state == ST_ACC1) && (is_modify || out_free)) ||
                      ((state == ST_ACC2) && out_free);
  assign out_load   = step && !((state == ST_ACC1) && is_modify);
  assign count_en   = step && !is_ignored;

  // second access of a modify works on the row the first one left
  assign row_cur = (state == ST_ACC2) ? row_hold : rd_row;

  salc_access #(
    .MAX_WAYS (MAX_WAYS),
    .AGE_W    (AGE_W)
  ) u_access (
    .way_en    (way_en),
    .valid_in  (row_cur.valid),
    .tag_in    (row_cur.tag),
    .age_in    (row_cur.age),
    .tag       (tag_r),
    .valid_out (row_new.valid),
    .tag_out   (row_new.tag),
    .age_out   (row_new.age),
    .res       (acc_res)
  );

  assign mem_we    = (state == ST_CLEAR) || count_en;
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : set_r;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (acc_fire) begin
      rd_row <= mem[set_idx];
    end
  end

  assign hits_seen_next      = hits_seen + salc_pkg::CNT_W'(acc_res.hit);
  assign misses_seen_next    = misses_seen + salc_pkg::CNT_W'(!acc_res.hit);
  assign evictions_seen_next = evictions_seen + salc_pkg::CNT_W'(acc_res.evict);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      res_valid      <= 1'b0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (count_en) begin
        hits_seen      <= hits_seen_next;
        misses_seen    <= misses_seen_next;
        evictions_seen <= evictions_seen_next;
      end

      if (out_load) begin
        if (state == ST_ACC2) begin
          res_outcome    <= first_outcome;
          res_second_hit <= acc_res.hit;
        end else begin
          res_outcome    <= is_ignored ? salc_pkg::OUT_IGNORED : acc_res.outcome;
          res_second_hit <= 1'b0;
        end
        res_hit_total      <= count_en ? hits_seen_next : hits_seen;
        res_miss_total     <= count_en ? misses_seen_next : misses_seen;
        res_eviction_total <= count_en ? evictions_seen_next : evictions_seen;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == LAST_SET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_fire) begin
            cmd_r <= salc_pkg::cmd_t'(access.command);
            set_r <= set_idx;
            tag_r <= tag_val;
            state <= ST_ACC1;
          end
        end
        ST_ACC1: begin
          if (step) begin
            if (is_modify) begin
              row_hold      <= row_new;
              first_outcome <= acc_res.outcome;
              state         <= ST_ACC2;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_ACC2: begin
          if (step) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.outcome        = res_outcome;
  assign result.second_hit     = res_second_hit;
  assign result.hit_total      = res_hit_total;
  assign result.miss_total     = res_miss_total;
  assign result.eviction_total = res_eviction_total;

  // a modify's second access must find the line its first access left
  a_second_hits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC2) |-> acc_res.hit)
    else $error("modify second access missed");

  // every eviction is also counted as a miss
  a_evict_with_miss: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (evictions_seen != $past(evictions_seen)))
      |-> (misses_seen != $past(misses_seen)))
    else $error("eviction counted without a miss");

  // the set memory is only written by the clear pass or an access update
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("set memory written while idle");

  // no access is taken before the clear pass is done
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !access.ready)
    else $error("access accepted during clear pass");

endmodule

// ===== hw/rtl/salc_access.sv =====
// salc_access: one lookup on a set row: tag match, fill or lru victim, age update
// depends on salc_pkg; instantiated by set_assoc_lru_cache_sim
module salc_access #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
  parameter int AGE_W    = 3
) (
  input  logic [MAX_WAYS-1:0]                        way_en,
  input  logic [MAX_WAYS-1:0]                        valid_in,
  input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]   tag_in,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]             age_in,
  input  logic [salc_pkg::TAG_W-1:0]                 tag,
  output logic [MAX_WAYS-1:0]                        valid_out,
  output logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0]   tag_out,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]             age_out,
  output salc_pkg::acc_res_t                         res
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic                hit_any;
  logic                inv_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    vic_way;
  logic [AGE_W-1:0]    vic_age;
  logic [WAY_W-1:0]    sel_way;
  logic [AGE_W-1:0]    old_age;
  logic                fill;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      hit_vec[i] = way_en[i] && valid_in[i] && (tag_in[i] == tag);
      inv_vec[i] = way_en[i] && !valid_in[i];
    end
  end

  // lowest-numbered match and lowest-numbered empty way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (inv_vec[i]) begin
        inv_way = WAY_W'(i);
      end
    end
  end

  assign hit_any = |hit_vec;
  assign inv_any = |inv_vec;

  // strict compare keeps the lowest way among equal oldest ranks
  always_comb begin
    vic_way = '0;
    vic_age = age_in[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (way_en[i] && (age_in[i] > vic_age)) begin
        vic_way = WAY_W'(i);
        vic_age = age_in[i];
      end
    end
  end

  always_comb begin
    if (hit_any) begin
      sel_way = hit_way;
      old_age = age_in[hit_way];
      fill    = 1'b0;
    end else if (inv_any) begin
      sel_way = inv_way;
      old_age = '0;
      fill    = 1'b1;
    end else begin
      sel_way = vic_way;
      old_age = vic_age;
      fill    = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      valid_out[i] = valid_in[i];
      tag_out[i]   = tag_in[i];
      age_out[i]   = age_in[i];
      if (WAY_W'(i) == sel_way) begin
        age_out[i] = '0;
        if (!hit_any) begin
          valid_out[i] = 1'b1;
          tag_out[i]   = tag;
        end
      end else if (way_en[i] && valid_in[i] && (fill || (age_in[i] < old_age))
                   && (age_in[i] != AGE_MAX)) begin
        age_out[i] = age_in[i] + AGE_W'(1);
      end
    end
  end

  always_comb begin
    res.hit   = hit_any;
    res.evict = !hit_any && !inv_any;
    if (hit_any) begin
      res.outcome = salc_pkg::OUT_HIT;
    end else if (inv_any) begin
      res.outcome = salc_pkg::OUT_MISS;
    end else begin
      res.outcome = salc_pkg::OUT_EVICT;
    end
  end

endmodule
